// ===== src/u2g_pkg.sv =====
`timescale 1ns / 1ps

package u2g_pkg;

  localparam logic [7:0] ASCII_LO   = 8'h20;
  localparam logic [7:0] ASCII_HI   = 8'h7E;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] LATIN_LO   = 8'hA0;
  localparam logic [7:0] LATIN_BASE = 8'd95;
  localparam logic [7:0] PUNCT_BASE = 8'd191;
  localparam int         NUM_PUNCT  = 8;
  localparam int         MAX_RES    = 3;

  localparam logic [15:0] PUNCT_POINTS [NUM_PUNCT] = '{
    16'h2013, 16'h2014, 16'h2015, 16'h2018,
    16'h2019, 16'h201C, 16'h201D, 16'h2026
  };

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] glyph_index;
    logic       is_glyph;
    logic [1:0] bytes_taken;
    logic       last_of_run;
  } out_word_t;

  // all results caused by one input byte; count is 1..3
  typedef struct packed {
    logic [1:0]                   count;
    out_word_t [MAX_RES-1:0]      res;
  } bundle_t;

  typedef struct packed {
    logic      done;   // 0: lead must wait for more bytes
    out_word_t res;
  } decision_t;

  // Decide on lead c with b1, b2 following; avail = bytes present from c on.
  function automatic decision_t decide(logic [7:0] c, logic [7:0] b1, logic [7:0] b2,
                                       logic [1:0] avail, logic fin);
    decision_t   d;
    logic [10:0] cp2;
    logic [15:0] cp3;
    logic        hit;
    logic [2:0]  hit_idx;
    d.done             = 1'b1;
    d.res.glyph_index  = 8'd0;
    d.res.is_glyph     = 1'b0;
    d.res.bytes_taken  = 2'd1;
    d.res.last_of_run  = 1'b0;
    cp2     = {c[4:0], b1[5:0]};
    cp3     = {c[3:0], b1[5:0], b2[5:0]};
    hit     = 1'b0;
    hit_idx = 3'd0;
    for (int i = 0; i < NUM_PUNCT; i++) begin
      if (!hit && cp3 == PUNCT_POINTS[i]) begin
        hit     = 1'b1;
        hit_idx = 3'(i);
      end
    end
    if (c >= ASCII_LO && c <= ASCII_HI) begin
      d.res.glyph_index = c - ASCII_LO;
      d.res.is_glyph    = 1'b1;
    end else if ((c & LEAD2_MASK) == LEAD2_CODE) begin
      if (avail < 2'd2 && !fin) begin
        d.done = 1'b0;
      end else if (avail >= 2'd2 && (b1 & CONT_MASK) == CONT_CODE &&
                   cp2[10:8] == 3'd0 && cp2[7:0] >= LATIN_LO) begin
        d.res.glyph_index = cp2[7:0] - LATIN_LO + LATIN_BASE;
        d.res.is_glyph    = 1'b1;
        d.res.bytes_taken = 2'd2;
      end
    end else if ((c & LEAD3_MASK) == LEAD3_CODE) begin
      if (avail < 2'd3 && !fin) begin
        d.done = 1'b0;
      end else if (avail == 2'd3 && (b1 & CONT_MASK) == CONT_CODE &&
                   (b2 & CONT_MASK) == CONT_CODE && hit) begin
        d.res.glyph_index = PUNCT_BASE + {5'd0, hit_idx};
        d.res.is_glyph    = 1'b1;
        d.res.bytes_taken = 2'd3;
      end
    end
    return d;
  endfunction

endpackage

// ===== src/u2g_stream_if.sv =====
`timescale 1ns / 1ps

interface u2g_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/utf8_to_glyph_index_core.sv =====
`timescale 1ns / 1ps

// UTF-8 text to glyph index decoder.
// in_ch  (sink):   one text byte per word plus end_of_text on the last byte of a string.
// out_ch (source): one decision per word: glyph_index, is_glyph, bytes_taken, and
//                  last_of_run on the final decision caused by an input byte.
// ASCII 0x20..0x7E -> 0..94, U+00A0..U+00FF -> 95..190, eight punctuation
// codepoints -> 191..198; anything else skips one byte and rescans the rest.
// Each result is written into the bundle queue before it appears on out_ch.
// Intake: one input byte per cycle while the queue has room; a byte that yields k
// results (k = 0..3) leaves as k words in turn through the single output port.
// Bytes that only extend a pending lead yield no word.
// The front and the output side are split by a bundle queue of QUEUE_DEPTH
// entries; in_ch.ready drops only when that queue is full, so an output stall
// backs up into the input after QUEUE_DEPTH bundles.
// Reset (rst, synchronous) drops any held partial sequence and empties the queue.
module utf8_to_glyph_index_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  u2g_stream_if.sink    in_ch,
  u2g_stream_if.source  out_ch
);

  // front -> queue
  logic              push_valid;
  logic              push_ready;
  u2g_pkg::bundle_t  push_data;

  // queue -> back
  logic              pop_valid;
  logic              pop_ready;
  u2g_pkg::bundle_t  pop_data;

  // byte classification and held-lead tracking
  u2g_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouples byte intake from multi-word output bursts
  u2g_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // serializes each bundle onto out_ch
  u2g_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

// ===== src/u2g_front.sv =====
`timescale 1ns / 1ps

// Holds partial sequences and turns each byte into a bundle of 0..3 results.
module u2g_front (
  input  logic              clk,
  input  logic              rst,
  u2g_stream_if.sink        in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output u2g_pkg::bundle_t  push_data
);

  logic [7:0] held_lead, held_lead_next;
  logic [7:0] held_second, held_second_next;
  logic [1:0] held_count, held_count_next;

  logic [7:0]          bytes [3];
  logic [1:0]          n;
  logic [1:0]          start;
  logic                stop;
  logic [1:0]          cnt;
  logic [1:0]          rem;
  u2g_pkg::decision_t  d;
  u2g_pkg::bundle_t    bundle;
  logic                fin;
  logic                accept;

  function automatic logic [7:0] byte_at(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                         logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = b0;
      3'd1:    r = b1;
      3'd2:    r = b2;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  assign fin         = in_ch.data.end_of_text;
  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    bytes[0] = 8'd0;
    bytes[1] = 8'd0;
    bytes[2] = 8'd0;
    unique case (held_count)
      2'd0: begin
        bytes[0] = in_ch.data.text_byte;
        n        = 2'd1;
      end
      2'd1: begin
        bytes[0] = held_lead;
        bytes[1] = in_ch.data.text_byte;
        n        = 2'd2;
      end
      default: begin
        bytes[0] = held_lead;
        bytes[1] = held_second;
        bytes[2] = in_ch.data.text_byte;
        n        = 2'd3;
      end
    endcase

    // up to three decisions, each starting where the last one ended
    start  = 2'd0;
    stop   = 1'b0;
    cnt    = 2'd0;
    bundle = '0;
    d      = '0;
    for (int k = 0; k < u2g_pkg::MAX_RES; k++) begin
      if (!stop && start < n) begin
        d = u2g_pkg::decide(byte_at(bytes[0], bytes[1], bytes[2], {1'b0, start}),
                            byte_at(bytes[0], bytes[1], bytes[2], {1'b0, start} + 3'd1),
                            byte_at(bytes[0], bytes[1], bytes[2], {1'b0, start} + 3'd2),
                            n - start, fin);
        if (!d.done) begin
          stop = 1'b1;
        end else begin
          bundle.res[k] = d.res;
          cnt           = cnt + 2'd1;
          start         = start + d.res.bytes_taken;
        end
      end
    end
    for (int k = 0; k < u2g_pkg::MAX_RES; k++) begin
      bundle.res[k].last_of_run = (cnt != 2'd0) && (2'(k) == cnt - 2'd1);
    end
    bundle.count = cnt;

    rem              = n - start;
    held_count_next  = rem;
    held_lead_next   = (rem >= 2'd1) ?
                       byte_at(bytes[0], bytes[1], bytes[2], {1'b0, start}) : 8'd0;
    held_second_next = (rem >= 2'd2) ?
                       byte_at(bytes[0], bytes[1], bytes[2], {1'b0, start} + 3'd1) : 8'd0;
  end

  assign push_valid = in_ch.valid && (cnt != 2'd0);
  assign push_data  = bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead   <= 8'd0;
      held_second <= 8'd0;
      held_count  <= 2'd0;
    end else if (accept) begin
      held_lead   <= held_lead_next;
      held_second <= held_second_next;
      held_count  <= held_count_next;
    end
  end

endmodule

// ===== src/u2g_queue.sv =====
`timescale 1ns / 1ps

// Small bundle queue between front and back.
module u2g_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  u2g_pkg::bundle_t  push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output u2g_pkg::bundle_t  pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u2g_pkg::bundle_t  mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ===== src/u2g_back.sv =====
`timescale 1ns / 1ps

// Steps through the results of the head bundle, one word per cycle while out_ch.ready is high.
module u2g_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  u2g_pkg::bundle_t  pop_data,
  u2g_stream_if.source      out_ch
);

  logic [1:0]          idx;
  u2g_pkg::out_word_t  cur;
  logic                out_acc;

  assign cur          = pop_data.res[idx];
  assign out_ch.valid = pop_valid;
  assign out_ch.data  = cur;
  assign out_acc      = out_ch.valid && out_ch.ready;
  assign pop_ready    = out_ch.ready && cur.last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (out_acc) begin
      idx <= cur.last_of_run ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// ===== src/u2g_checker.sv =====
`timescale 1ns / 1ps

module u2g_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] glyph_index,
  input logic       is_glyph,
  input logic [1:0] bytes_taken,
  input logic       last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(glyph_index) && $stable(is_glyph) && $stable(bytes_taken) &&
      $stable(last_of_run))
    else $error("output word changed while stalled");

  a_skip_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_glyph |-> glyph_index == 8'd0 && bytes_taken == 2'd1)
    else $error("skip word malformed");

  a_glyph_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_glyph |->
      (glyph_index < 8'd95 && bytes_taken == 2'd1) ||
      (glyph_index >= 8'd95 && glyph_index < 8'd191 && bytes_taken == 2'd2) ||
      (glyph_index >= 8'd191 && glyph_index <= 8'd198 && bytes_taken == 2'd3))
    else $error("glyph index does not match byte count");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind utf8_to_glyph_index_core u2g_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .glyph_index (out_ch.data.glyph_index),
  .is_glyph    (out_ch.data.is_glyph),
  .bytes_taken (out_ch.data.bytes_taken),
  .last_of_run (out_ch.data.last_of_run)
);
